/* hw/rtl/ps2s3_pkg.sv */
// ps2s3_pkg: shared types and constants for the scan code set 3 key state tracker
// link mode encoding, protocol bytes, key event codes, request kinds, default key map depth and the control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ps2s3_pkg;

    // protocol bytes
    localparam logic [7:0] CMD_RESET  = 8'hFF;
    localparam logic [7:0] CMD_CONFIG = 8'hF8;
    localparam logic [7:0] CMD_NONE   = 8'h00;
    localparam logic [7:0] BYTE_ACK   = 8'hFA;
    localparam logic [7:0] BYTE_PASS  = 8'hAA;
    localparam logic [7:0] BYTE_BREAK = 8'hF0;
    localparam logic [7:0] BYTE_NONE  = 8'h00;

    // key event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_MAKE  = 2'd1;
    localparam logic [1:0] EV_BREAK = 2'd2;
    localparam logic [1:0] EV_DROP  = 2'd3;

    // request kinds
    localparam logic REQ_POLL = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // default key map depth in rows of 8 keys
    localparam int ROWS_DEFAULT = 17;

    typedef enum logic [6:0] {
        MODE_RESET  = 7'b0000001,
        MODE_SELFT  = 7'b0000010,
        MODE_ID0    = 7'b0000100,
        MODE_ID1    = 7'b0001000,
        MODE_CONFIG = 7'b0010000,
        MODE_READY  = 7'b0100000,
        MODE_BREAK  = 7'b1000000
    } t_link_mode;

    // link controller to key map and result stage
    typedef struct packed {
        logic [7:0] cmd;
        logic       ready;
        logic [1:0] event_code;
        logic       map_we;
        logic       map_set;
    } t_link_ctl;

endpackage

`default_nettype wire

/* hw/rtl/ps2s3_link_fsm.sv */
// ps2s3_link_fsm: link handshake state machine and scan code decode
// depends on ps2s3_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2s3_link_fsm #(
    parameter int ROWS = ps2s3_pkg::ROWS_DEFAULT
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  wire                   i_req,
    input  wire [7:0]             i_code,
    input  wire [7:0]             i_reply,
    output ps2s3_pkg::t_link_ctl  o_ctl
);

    ps2s3_pkg::t_link_mode r_mode;
    ps2s3_pkg::t_link_mode n_mode;
    logic                  in_range;

    assign in_range = ({1'b0, i_code} < 9'(ROWS * 8));

    always_comb begin
        n_mode = r_mode;
        o_ctl  = '0;
        if (i_step && (i_req == ps2s3_pkg::REQ_POLL)) begin
            unique case (r_mode)
                ps2s3_pkg::MODE_SELFT: begin
                    if (i_code == ps2s3_pkg::BYTE_PASS) begin
                        n_mode = ps2s3_pkg::MODE_ID0;
                    end else if (i_code != ps2s3_pkg::BYTE_NONE) begin
                        n_mode = ps2s3_pkg::MODE_RESET;
                    end
                end
                ps2s3_pkg::MODE_ID0: begin
                    if (i_code != ps2s3_pkg::BYTE_NONE) begin
                        n_mode = ps2s3_pkg::MODE_ID1;
                    end
                end
                ps2s3_pkg::MODE_ID1: begin
                    if (i_code != ps2s3_pkg::BYTE_NONE) begin
                        n_mode = ps2s3_pkg::MODE_CONFIG;
                    end
                end
                ps2s3_pkg::MODE_CONFIG: begin
                    o_ctl.cmd = ps2s3_pkg::CMD_CONFIG;
                    if (i_reply == ps2s3_pkg::BYTE_ACK) begin
                        n_mode = ps2s3_pkg::MODE_READY;
                    end
                end
                ps2s3_pkg::MODE_READY: begin
                    if (i_code == ps2s3_pkg::BYTE_BREAK) begin
                        n_mode = ps2s3_pkg::MODE_BREAK;
                    end else if (i_code != ps2s3_pkg::BYTE_NONE) begin
                        if (in_range) begin
                            o_ctl.map_we     = 1'b1;
                            o_ctl.map_set    = 1'b1;
                            o_ctl.event_code = ps2s3_pkg::EV_MAKE;
                        end else begin
                            o_ctl.event_code = ps2s3_pkg::EV_DROP;
                        end
                    end
                end
                ps2s3_pkg::MODE_BREAK: begin
                    if (i_code != ps2s3_pkg::BYTE_NONE) begin
                        n_mode = ps2s3_pkg::MODE_READY;
                        if (in_range) begin
                            o_ctl.map_we     = 1'b1;
                            o_ctl.event_code = ps2s3_pkg::EV_BREAK;
                        end else begin
                            o_ctl.event_code = ps2s3_pkg::EV_DROP;
                        end
                    end
                end
                default: begin
                    // reset mode: keep sending reset until acked
                    o_ctl.cmd = ps2s3_pkg::CMD_RESET;
                    n_mode    = (i_reply == ps2s3_pkg::BYTE_ACK) ?
                                ps2s3_pkg::MODE_SELFT : ps2s3_pkg::MODE_RESET;
                end
            endcase
        end
        o_ctl.ready = (n_mode == ps2s3_pkg::MODE_READY) ||
                      (n_mode == ps2s3_pkg::MODE_BREAK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ps2s3_pkg::MODE_RESET;
        end else begin
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ps2s3_key_map.sv */
// ps2s3_key_map: ROWS x 8 key state bits, single bit set or clear, one row read port
// depends on ps2s3_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2s3_key_map #(
    parameter int ROWS = ps2s3_pkg::ROWS_DEFAULT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_we,
    input  wire        i_set,
    input  wire [7:0]  i_code,
    input  wire [4:0]  i_rd_row,
    output logic [7:0] o_rd_bits
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [7:0]    r_map [ROWS];
    logic [RW-1:0] wr_row;
    logic [2:0]    wr_col;

    // code is already range checked, so the row fits
    assign wr_row = i_code[3 +: RW];
    assign wr_col = i_code[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_map[r] <= '0;
            end
        end else if (i_we) begin
            r_map[wr_row][wr_col] <= i_set;
        end
    end

    // out of range rows read as zero
    always_comb begin
        if ({1'b0, i_rd_row} < 6'(ROWS)) begin
            o_rd_bits = r_map[i_rd_row[RW-1:0]];
        end else begin
            o_rd_bits = '0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ps2s3_key_state_tracker_top_unused_guard.sv */
// ps2s3_out_reg: result register with stream handshake toward the consumer
// depends on ps2s3_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2s3_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  ps2s3_pkg::t_link_ctl  i_ctl,
    input  wire [7:0]             i_row_bits,
    input  wire                   i_tready,
    output logic                  o_tvalid,
    output logic                  o_free,
    output logic [23:0]           o_tdata
);

    logic       r_valid;
    logic [7:0] r_cmd;
    logic       r_ready;
    logic [1:0] r_event;
    logic [7:0] r_bits;

    // slot can take a beat when empty or draining this cycle
    assign o_free   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_tdata  = {5'd0, r_bits, r_event, r_ready, r_cmd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_cmd   <= i_ctl.cmd;
            r_ready <= i_ctl.ready;
            r_event <= i_ctl.event_code;
            r_bits  <= i_row_bits;
        end
    end

    // a command beat never carries a key event or row data
    a_cmd_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_cmd != ps2s3_pkg::CMD_NONE)) |->
        (r_event == ps2s3_pkg::EV_NONE && r_bits == 8'd0))
    else $error("command beat carries a key event or row data");

endmodule

`default_nettype wire

/* hw/rtl/ps2_set3_key_state_tracker.sv */
// ps2_set3_key_state_tracker: top level of the scan code set 3 host side key tracker
// one input beat per cycle while m_axis_tready keeps the result slot free
// path: input register -> decode and key map -> result register
// synchronous active low reset returns the link to reset mode and clears every key bit at once
// depends on ps2s3_pkg, ps2s3_link_fsm, ps2s3_key_map, ps2s3_out_reg
`timescale 1ns / 1ps
`default_nettype none

module ps2_set3_key_state_tracker #(
    parameter int ROWS = ps2s3_pkg::ROWS_DEFAULT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input beats
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [23:0]  s_axis_tdata,   // rx_code[7:0], cmd_reply[15:8], row_index[20:16]
    input  wire         s_axis_tuser,   // req_type[0]
    // result beats
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata    // cmd_sent[7:0], link_ready[8], key_event[10:9],
                                        // row_bits[18:11]
);

    // input register
    logic       r_in_valid;
    logic       r_req;
    logic [7:0] r_code;
    logic [7:0] r_reply;
    logic [4:0] r_row;

    logic                 out_free;
    logic                 advance;
    logic                 s_accept;
    ps2s3_pkg::t_link_ctl ctl;
    logic [7:0]           rd_bits;
    logic [7:0]           row_bits;

    // an item leaves the input register when the result slot can take it
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req   <= s_axis_tuser;
            r_code  <= s_axis_tdata[7:0];
            r_reply <= s_axis_tdata[15:8];
            r_row   <= s_axis_tdata[20:16];
        end
    end

    // link state only moves when the item is committed to the result register
    ps2s3_link_fsm #(
        .ROWS (ROWS)
    ) u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_req),
        .i_code  (r_code),
        .i_reply (r_reply),
        .o_ctl   (ctl)
    );

    ps2s3_key_map #(
        .ROWS (ROWS)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (ctl.map_we),
        .i_set     (ctl.map_set),
        .i_code    (r_code),
        .i_rd_row  (r_row),
        .o_rd_bits (rd_bits)
    );

    // poll beats always report an empty row
    assign row_bits = (r_req == ps2s3_pkg::REQ_READ) ? rd_bits : 8'd0;

    ps2s3_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_ctl      (ctl),
        .i_row_bits (row_bits),
        .i_tready   (m_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .o_free     (out_free),
        .o_tdata    (m_axis_tdata)
    );

    // key map writes only happen for items that are being committed
    a_we_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.map_we |-> advance)
    else $error("key map written without a committed item");

    // a key event (make, break or drop) only comes out while the link is ready
    a_event_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[10:9] != ps2s3_pkg::EV_NONE)) |-> m_axis_tdata[8])
    else $error("key event reported while link not ready");

    // row reads never send a command, report an event nor write the key map
    a_read_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_req == ps2s3_pkg::REQ_READ)) |->
        (ctl.cmd == ps2s3_pkg::CMD_NONE && ctl.event_code == ps2s3_pkg::EV_NONE
         && !ctl.map_we))
    else $error("row read disturbed link state");

    // a stalled input item stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
    else $error("input item lost while result slot busy");

endmodule

`default_nettype wire
